// ----- rtl/pfr_pkg.sv -----
// Package for the pose frame receiver: status codes, framing constants,
// register indexes and the byte-wide CRC-16 function. No dependencies.
package pfr_pkg;

	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_BYTE     = 3'd1,
		ST_VALID    = 3'd2,
		ST_CRC_ERR  = 3'd3,
		ST_TRL_ERR  = 3'd4,
		ST_INVALID  = 3'd5,
		ST_TIMEOUT  = 3'd6
	} status_t;

	localparam logic [1:0] REG_INTERBYTE = 2'd0;
	localparam logic [1:0] REG_POSE_TO   = 2'd1;
	localparam logic [1:0] REG_LINK_TO   = 2'd2;
	localparam logic [1:0] REG_INV_COORD = 2'd3;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [7:0]  SOF0          = 8'hAA;
	localparam logic [7:0]  SOF1_LEGACY   = 8'h55;
	localparam logic [7:0]  SOF1_EXTENDED = 8'h56;
	localparam logic [7:0]  TRAIL0        = 8'h0D;
	localparam logic [7:0]  TRAIL1        = 8'h0A;
	localparam logic [3:0]  LEN_LEGACY    = 4'd14;
	localparam logic [3:0]  LEN_EXTENDED  = 4'd15;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] pose_x;
		logic [31:0] pose_y;
		logic [31:0] valid_frame_count;
		logic        pose_usable;
		logic        takeoff_permit;
		logic        link_alive;
		logic [31:0] crc_error_count;
		logic [31:0] trailer_error_count;
		logic [31:0] invalid_frame_count;
		logic [31:0] timeout_count;
		logic [31:0] byte_count;
	} result_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  byte_value;
	} item_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- rtl/pfr_if.sv -----
// Valid/ready channel interfaces for the pose frame receiver.
// Depends on pfr_pkg for the payload types.
interface pfr_item_if import pfr_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pfr_result_if import pfr_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pfr_cfg_if ();
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/pfr_cfg_regs.sv -----
// Configuration register file of the pose frame receiver.
// Depends on pfr_pkg and the pfr_cfg_if interface.
module pfr_cfg_regs import pfr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pfr_cfg_if.sink      cfg,
	output logic [15:0]  interbyte_timeout,
	output logic [15:0]  pose_valid_timeout,
	output logic [15:0]  link_timeout,
	output logic [31:0]  invalid_coordinate
);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interbyte_timeout  <= 16'd100;
			pose_valid_timeout <= 16'd500;
			link_timeout       <= 16'd1000;
			invalid_coordinate <= 32'h8000_0000;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_INTERBYTE: interbyte_timeout  <= cfg.wdata[15:0];
				REG_POSE_TO:   pose_valid_timeout <= cfg.wdata[15:0];
				REG_LINK_TO:   link_timeout       <= cfg.wdata[15:0];
				REG_INV_COORD: invalid_coordinate <= cfg.wdata;
				default: ;
			endcase
		end
	end
endmodule

// ----- rtl/pose_frame_receiver_unit.sv -----
// Top level of the pose frame receiver: deframer, checks, timeouts, counters.
// Depends on pfr_pkg, the interfaces in pfr_if and pfr_cfg_regs.
//
// Use: items enter on in_ch, one beat each; mode 0 carries a received serial
// byte, mode 1 a one-millisecond tick. Every accepted beat yields exactly one
// result beat on out_ch with the status of that item and a full snapshot of
// the pose, the flags and the statistics counters. Configuration beats on
// cfg_ch write the timeouts and the sentinel coordinate; they are always
// accepted and should only be sent while the block is idle.
// The state is updated at the accepting edge and the result register holds the
// beat from the next cycle. Throughput is one item per cycle while out_ch is
// not stalled; the byte-wide CRC step and frame checks are combinational.
// The result register forms a one-deep output stage: in_ch is ready whenever
// that register is empty or is being emptied in the same cycle, so a stalled
// receiver holds the pending beat and back-pressures the input.
// Reset clears the frame position, elapsed counters, flags and all statistics,
// presets the CRC and loads the register defaults; the frame bytes are not reset.
module pose_frame_receiver_unit import pfr_pkg::*; #(
	parameter int ELAPSED_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	pfr_item_if.sink      in_ch,
	pfr_result_if.source  out_ch,
	pfr_cfg_if.sink       cfg_ch
);
	localparam logic [ELAPSED_WIDTH-1:0] EL_MAX = '1;

	logic [15:0] ib_to, pv_to, lk_to;
	logic [31:0] inv_c;

	pfr_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch),
		.interbyte_timeout(ib_to), .pose_valid_timeout(pv_to),
		.link_timeout(lk_to), .invalid_coordinate(inv_c)
	);

	// Architectural state.
	logic [3:0]  pos_q;
	logic        ext_q;
	logic [15:0] crc_q;
	logic [7:0]  fb_q [15];
	logic [ELAPSED_WIDTH-1:0] sb_q, sf_q, sp_q;
	logic        seen_q, valid_q, tko_q;
	logic [31:0] hx_q, hy_q;
	logic [31:0] c_bytes_q, c_valid_q, c_crc_q, c_trl_q, c_inv_q, c_to_q;

	logic    out_v_q;
	result_t out_q;
	logic    acc;

	assign in_ch.ready  = !out_v_q || out_ch.ready;
	assign acc          = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	// Next-state logic for one item.
	logic [3:0]  pos_d, np;
	logic        ext_d;
	logic [15:0] crc_d;
	logic [ELAPSED_WIDTH-1:0] sb_d, sf_d, sp_d;
	logic        seen_d, valid_d, tko_d, alive;
	logic [31:0] hx_d, hy_d;
	logic [31:0] c_bytes_d, c_valid_d, c_crc_d, c_trl_d, c_inv_d, c_to_d;
	logic [2:0]  st;
	logic        wr_en;
	logic [3:0]  wr_at;
	logic [7:0]  b, flag, t0, t1, k0, k1;
	logic [3:0]  len;
	logic [31:0] fx, fy;

	always_comb begin
		b = in_ch.data.byte_value;
		pos_d = pos_q; ext_d = ext_q; crc_d = crc_q;
		sb_d = sb_q; sf_d = sf_q; sp_d = sp_q;
		seen_d = seen_q; valid_d = valid_q; tko_d = tko_q;
		hx_d = hx_q; hy_d = hy_q;
		c_bytes_d = c_bytes_q; c_valid_d = c_valid_q; c_crc_d = c_crc_q;
		c_trl_d = c_trl_q; c_inv_d = c_inv_q; c_to_d = c_to_q;
		st = ST_NONE; wr_en = 1'b0; wr_at = pos_q; np = '0;
		len = ext_q ? LEN_EXTENDED : LEN_LEGACY;
		// The final byte is not yet stored, so take it from the input.
		flag = ext_q ? fb_q[10] : 8'h00;
		k0 = ext_q ? fb_q[11] : fb_q[10];
		k1 = ext_q ? fb_q[12] : fb_q[11];
		t0 = ext_q ? fb_q[13] : fb_q[12];
		t1 = b;
		fx = {fb_q[5], fb_q[4], fb_q[3], fb_q[2]};
		fy = {fb_q[9], fb_q[8], fb_q[7], fb_q[6]};
		if (in_ch.data.mode) begin
			if (sb_q != EL_MAX) sb_d = sb_q + 1'b1;
			if (sf_q != EL_MAX) sf_d = sf_q + 1'b1;
			if (sp_q != EL_MAX) sp_d = sp_q + 1'b1;
		end else begin
			st = ST_BYTE;
			c_bytes_d = c_bytes_q + 1'b1;
			sb_d = '0;
			if (pos_q != 4'd0 && sb_q > ELAPSED_WIDTH'(ib_to)) begin
				c_to_d = c_to_q + 1'b1;
				pos_d = 4'd0; ext_d = 1'b0; st = ST_TIMEOUT;
			end
			if (pos_d == 4'd0) begin
				if (b == SOF0) begin
					wr_en = 1'b1; wr_at = 4'd0; pos_d = 4'd1;
				end
			end else if (pos_q == 4'd1) begin
				if (b == SOF1_LEGACY || b == SOF1_EXTENDED) begin
					wr_en = 1'b1; wr_at = 4'd1; pos_d = 4'd2;
					ext_d = (b == SOF1_EXTENDED); crc_d = CRC_INIT;
				end else begin
					ext_d = 1'b0;
					pos_d = (b == SOF0) ? 4'd1 : 4'd0;
					wr_en = (b == SOF0); wr_at = 4'd0;
				end
			end else begin
				wr_en = (pos_q != 4'd15); wr_at = pos_q;
				if (pos_q < len - 4'd4) crc_d = crc_byte(crc_q, b);
				np = pos_q + 4'd1;
				pos_d = np;
				if (np >= len || np == 4'd0) begin
					pos_d = 4'd0; ext_d = 1'b0;
					if (flag > 8'd1) begin
						c_inv_d = c_inv_q + 1'b1; st = ST_INVALID;
					end else if (t0 != TRAIL0 || t1 != TRAIL1) begin
						c_trl_d = c_trl_q + 1'b1; st = ST_TRL_ERR;
					end else if ({k1, k0} != crc_q) begin
						c_crc_d = c_crc_q + 1'b1; st = ST_CRC_ERR;
					end else begin
						sf_d = '0; seen_d = 1'b1; tko_d = flag[0];
						if (fx == inv_c || fy == inv_c) begin
							c_inv_d = c_inv_q + 1'b1; valid_d = 1'b0; st = ST_INVALID;
						end else begin
							c_valid_d = c_valid_q + 1'b1;
							hx_d = fx; hy_d = fy; sp_d = '0; valid_d = 1'b1;
							st = ST_VALID;
						end
					end
				end
			end
		end
		if (valid_d && sp_d > ELAPSED_WIDTH'(pv_to))
			valid_d = 1'b0;
		if (tko_d && sf_d > ELAPSED_WIDTH'(lk_to))
			tko_d = 1'b0;
		alive = seen_d && (sf_d <= ELAPSED_WIDTH'(lk_to));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; ext_q <= 1'b0; crc_q <= CRC_INIT;
			sb_q <= '0; sf_q <= '0; sp_q <= '0;
			seen_q <= 1'b0; valid_q <= 1'b0; tko_q <= 1'b0;
			hx_q <= '0; hy_q <= '0;
			c_bytes_q <= '0; c_valid_q <= '0; c_crc_q <= '0;
			c_trl_q <= '0; c_inv_q <= '0; c_to_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				pos_q <= pos_d; ext_q <= ext_d; crc_q <= crc_d;
				sb_q <= sb_d; sf_q <= sf_d; sp_q <= sp_d;
				seen_q <= seen_d; valid_q <= valid_d; tko_q <= tko_d;
				hx_q <= hx_d; hy_q <= hy_d;
				c_bytes_q <= c_bytes_d; c_valid_q <= c_valid_d; c_crc_q <= c_crc_d;
				c_trl_q <= c_trl_d; c_inv_q <= c_inv_d; c_to_q <= c_to_d;
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Frame bytes and the result payload need no reset.
	always_ff @(posedge clk) begin
		if (acc && wr_en) fb_q[wr_at] <= b;
		if (acc) begin
			out_q.status              <= st;
			out_q.pose_x              <= hx_d;
			out_q.pose_y              <= hy_d;
			out_q.valid_frame_count   <= c_valid_d;
			out_q.pose_usable         <= valid_d;
			out_q.takeoff_permit      <= tko_d && alive;
			out_q.link_alive          <= alive;
			out_q.crc_error_count     <= c_crc_d;
			out_q.trailer_error_count <= c_trl_d;
			out_q.invalid_frame_count <= c_inv_d;
			out_q.timeout_count       <= c_to_d;
			out_q.byte_count          <= c_bytes_d;
		end
	end

`ifndef SYNTHESIS
	// A stalled result beat must not be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |-> !acc) else $error("result overwritten");
	// The frame position never passes the extended frame length.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < LEN_EXTENDED) else $error("frame position out of range");
	// Every accepted byte advances the byte counter by one.
	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !in_ch.data.mode |=> c_bytes_q == $past(c_bytes_q) + 32'd1)
		else $error("byte count slip");
	// Before the second start byte is taken, the extended mark is never set.
	a_ext_pos: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < 4'd2 |-> !ext_q) else $error("extended mark outside frame");
`endif
endmodule

// ----- tb/pose_frame_receiver_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pose_frame_receiver_unit: frames, ticks and timeouts
// checked beat by beat against a behavioural predictor. Depends on pfr_pkg and pfr_if.
module pose_frame_receiver_unit_tb;
	import pfr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	pfr_item_if   in_ch ();
	pfr_result_if out_ch ();
	pfr_cfg_if    cfg_ch ();

	pose_frame_receiver_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	// Predictor state: a copy of the receiver's registers, kept at full width.
	logic [15:0] ib_to, pose_to, link_to;
	logic [31:0] sentinel;
	logic [3:0]  pos;
	logic        ext;
	logic [15:0] crc_acc;
	logic [7:0]  frm [0:14];
	logic [31:0] ms_byte, ms_frame, ms_pose;
	logic        seen, vflag, tflag;
	logic [31:0] hx, hy;
	logic [31:0] n_bytes, n_valid, n_crc, n_trl, n_inv, n_to;

	result_t expected_q [$];
	int      fails = 0;
	int      checked = 0;
	int      frames_good = 0;
	int      idle_cycles = 0;
	bit      in_pressure = 1'b1;

	// Bitwise CRC-16 with the 0x1021 polynomial, written independently of the package.
	function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			if (r[15] ^ b[i]) r = {r[14:0], 1'b0} ^ 16'h1021;
			else r = {r[14:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [31:0] le32(int at);
		return {frm[at + 3], frm[at + 2], frm[at + 1], frm[at]};
	endfunction

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	task automatic receiver_reset();
		ib_to = 16'd100; pose_to = 16'd500; link_to = 16'd1000;
		sentinel = 32'h8000_0000;
		pos = '0; ext = 1'b0; crc_acc = CRC_INIT;
		ms_byte = '0; ms_frame = '0; ms_pose = '0;
		seen = 1'b0; vflag = 1'b0; tflag = 1'b0; hx = '0; hy = '0;
		n_bytes = '0; n_valid = '0; n_crc = '0; n_trl = '0; n_inv = '0; n_to = '0;
	endtask

	// Checks a completed frame in the block's order: flag, trailer, CRC, sentinel.
	function automatic status_t close_frame();
		int          ca, ta;
		logic [7:0]  flag;
		logic [31:0] x, y;
		ca = ext ? 11 : 10;
		ta = ext ? 13 : 12;
		flag = ext ? frm[10] : 8'd0;
		if (flag > 8'd1) begin
			n_inv++;
			return ST_INVALID;
		end
		if (frm[ta] != TRAIL0 || frm[ta + 1] != TRAIL1) begin
			n_trl++;
			return ST_TRL_ERR;
		end
		if ({frm[ca + 1], frm[ca]} != crc_acc) begin
			n_crc++;
			return ST_CRC_ERR;
		end
		ms_frame = '0; seen = 1'b1; tflag = flag[0];
		x = le32(2); y = le32(6);
		if (x == sentinel || y == sentinel) begin
			n_inv++; vflag = 1'b0;
			return ST_INVALID;
		end
		n_valid++; hx = x; hy = y; ms_pose = '0; vflag = 1'b1;
		return ST_VALID;
	endfunction

	function automatic status_t take_serial_byte(logic [7:0] b);
		status_t st;
		int      flen;
		st = ST_BYTE;
		n_bytes++;
		if (pos != 0 && ms_byte > {16'd0, ib_to}) begin
			n_to++; pos = '0; ext = 1'b0; st = ST_TIMEOUT;
		end
		ms_byte = '0;
		if (pos == 0) begin
			if (b == SOF0) begin
				frm[0] = b; pos = 4'd1;
			end
			return st;
		end
		if (pos == 1) begin
			if (b == SOF1_LEGACY || b == SOF1_EXTENDED) begin
				frm[1] = b; pos = 4'd2; ext = (b == SOF1_EXTENDED); crc_acc = CRC_INIT;
			end else begin
				ext = 1'b0;
				pos = (b == SOF0) ? 4'd1 : 4'd0;
				if (b == SOF0) frm[0] = b;
			end
			return st;
		end
		flen = ext ? 15 : 14;
		if (pos < 15) frm[pos] = b;
		if (pos < flen - 4) crc_acc = crc_step(crc_acc, b);
		pos = pos + 4'd1;
		if (pos >= flen) begin
			st = close_frame();
			pos = '0; ext = 1'b0;
		end
		return st;
	endfunction

	function automatic result_t predict_result(item_t it);
		result_t r;
		logic    alive;
		r.status = ST_NONE;
		if (it.mode) begin
			ms_byte = sat_inc(ms_byte); ms_frame = sat_inc(ms_frame); ms_pose = sat_inc(ms_pose);
		end else begin
			r.status = take_serial_byte(it.byte_value);
		end
		if (vflag && ms_pose > {16'd0, pose_to}) vflag = 1'b0;
		if (tflag && ms_frame > {16'd0, link_to}) tflag = 1'b0;
		alive = seen && ms_frame <= {16'd0, link_to};
		if (r.status == ST_VALID) frames_good++;
		r.pose_x = hx; r.pose_y = hy; r.valid_frame_count = n_valid;
		r.pose_usable = vflag; r.takeoff_permit = tflag && alive; r.link_alive = alive;
		r.crc_error_count = n_crc; r.trailer_error_count = n_trl;
		r.invalid_frame_count = n_inv; r.timeout_count = n_to; r.byte_count = n_bytes;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fails++;
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// Stimulus: a flat list of items. Directed rows may pin the status they must give.
	item_t   stim_q [$];
	int      pin_q [$];

	task automatic push_item(logic m, logic [7:0] b, int pin);
		item_t it;
		it.mode = m; it.byte_value = b;
		stim_q.push_back(it);
		pin_q.push_back(pin);
	endtask

	// Builds a frame into the stimulus; corrupt selects a flaw: 0 none, 1 crc, 2 trailer,
	// 3 flag above one. The final byte's status is pinned when pin_last is set.
	task automatic push_frame(bit extd, logic [31:0] x, logic [31:0] y, logic [7:0] flag,
			int corrupt, int pin_last);
		logic [7:0]  body [$];
		logic [15:0] c;
		body = {SOF0, extd ? SOF1_EXTENDED : SOF1_LEGACY,
			x[7:0], x[15:8], x[23:16], x[31:24], y[7:0], y[15:8], y[23:16], y[31:24]};
		if (extd) body.push_back(corrupt == 3 ? 8'd2 + flag : flag);
		c = CRC_INIT;
		for (int i = 2; i < body.size(); i++) c = crc_step(c, body[i]);
		if (corrupt == 1) c = c ^ 16'h0100;
		body.push_back(c[7:0]);
		body.push_back(c[15:8]);
		body.push_back(corrupt == 2 ? 8'h0E : TRAIL0);
		body.push_back(TRAIL1);
		for (int i = 0; i < body.size(); i++)
			push_item(1'b0, body[i], (i == body.size() - 1) ? pin_last : -1);
	endtask

	task automatic push_ticks(int n);
		for (int i = 0; i < n; i++) push_item(1'b1, 8'($urandom), -1);
	endtask

	// Gap length: mostly short, now and then long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic config_write(logic [1:0] idx, logic [31:0] val);
		cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.wdata <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_INTERBYTE: ib_to = val[15:0];
			REG_POSE_TO:   pose_to = val[15:0];
			REG_LINK_TO:   link_to = val[15:0];
			default:       sentinel = val;
		endcase
	endtask

	// Sends the queued stimulus, predicting each beat at its accepting edge.
	task automatic send_items();
		item_t   it;
		int      pin;
		int      gap;
		result_t r;
		while (stim_q.size() > 0) begin
			it = stim_q.pop_front();
			pin = pin_q.pop_front();
			gap = in_pressure ? 0 : gap_len();
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_ch.valid <= 1'b1; in_ch.data <= it;
			@(posedge clk);
			while (!in_ch.ready) @(posedge clk);
			r = predict_result(it);
			if (pin >= 0 && r.status != pin[2:0])
				report_mismatch("directed status", 32'(r.status), 32'(pin));
			expected_q.push_back(r);
		end
		in_ch.valid <= 1'b0;
	endtask

	task automatic drain_results();
		while (expected_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver side: random stalls, with stretches of steady readiness.
	int ready_hold = 0;
	always @(posedge clk) begin
		if (ready_hold > 0) ready_hold <= ready_hold - 1;
		else if ($urandom_range(0, 9) < 3) begin
			out_ch.ready <= ~out_ch.ready;
			ready_hold <= gap_len();
		end
	end

	// Result checker: compares each accepted result beat with the oldest prediction.
	always @(posedge clk) begin
		result_t want, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result beat", 32'd1, 32'd0);
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.pose_x !== want.pose_x) report_mismatch("pose_x", got.pose_x, want.pose_x);
				if (got.pose_y !== want.pose_y) report_mismatch("pose_y", got.pose_y, want.pose_y);
				if (got.valid_frame_count !== want.valid_frame_count)
					report_mismatch("valid_frame_count", got.valid_frame_count,
						want.valid_frame_count);
				if (got.pose_usable !== want.pose_usable)
					report_mismatch("pose_usable", 32'(got.pose_usable), 32'(want.pose_usable));
				if (got.takeoff_permit !== want.takeoff_permit)
					report_mismatch("takeoff_permit", 32'(got.takeoff_permit),
						32'(want.takeoff_permit));
				if (got.link_alive !== want.link_alive)
					report_mismatch("link_alive", 32'(got.link_alive), 32'(want.link_alive));
				if (got.crc_error_count !== want.crc_error_count)
					report_mismatch("crc_error_count", got.crc_error_count, want.crc_error_count);
				if (got.trailer_error_count !== want.trailer_error_count)
					report_mismatch("trailer_error_count", got.trailer_error_count,
						want.trailer_error_count);
				if (got.invalid_frame_count !== want.invalid_frame_count)
					report_mismatch("invalid_frame_count", got.invalid_frame_count,
						want.invalid_frame_count);
				if (got.timeout_count !== want.timeout_count)
					report_mismatch("timeout_count", got.timeout_count, want.timeout_count);
				if (got.byte_count !== want.byte_count)
					report_mismatch("byte_count", got.byte_count, want.byte_count);
			end
		end
	end

	// Watchdog: counts cycles in which no beat moves on any channel.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("FAIL");
			$finish;
		end
	end

	// A random frame with random content and, now and then, a flaw or a sentinel coordinate.
	task automatic push_random_frame();
		logic [31:0] x, y;
		int          p, flaw;
		x = $urandom; y = $urandom;
		p = $urandom_range(0, 99);
		if (p < 8) x = sentinel;
		else if (p < 12) y = sentinel;
		flaw = 0;
		p = $urandom_range(0, 99);
		if (p < 8) flaw = 1;
		else if (p < 14) flaw = 2;
		else if (p < 18) flaw = 3;
		push_frame(1'($urandom_range(0, 1)), x, y, 8'($urandom_range(0, 1)), flaw, -1);
	endtask

	task automatic push_random_noise();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) push_ticks($urandom_range(1, 6));
		else if (p < 60) push_item(1'b0, 8'($urandom), -1);
		else if (p < 75) begin
			push_item(1'b0, SOF0, -1);
			push_item(1'b0, $urandom_range(0, 1) ? SOF0 : 8'($urandom), -1);
		end else begin
			// Partial frame followed by a pause, long enough to time it out when the
			// interbyte limit is short.
			push_item(1'b0, SOF0, -1);
			push_item(1'b0, SOF1_EXTENDED, -1);
			for (int i = 0; i < $urandom_range(1, 8); i++) push_item(1'b0, 8'($urandom), -1);
			if (ib_to < 16'd50) push_ticks(int'(ib_to) + 2);
			else push_ticks(4);
		end
	endtask

	initial begin
		in_ch.valid = 1'b0; in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0; cfg_ch.index = REG_INTERBYTE; cfg_ch.wdata = '0;
		receiver_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes, every status and the named special cases.
		push_item(1'b1, 8'h00, ST_NONE);
		push_item(1'b0, 8'hFF, ST_BYTE);
		push_item(1'b0, 8'h00, ST_BYTE);
		push_frame(1'b0, 32'h7FFF_FFFF, 32'h8000_0001, 8'd0, 0, ST_VALID);
		push_frame(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 8'd1, 0, ST_VALID);
		push_frame(1'b1, 32'd5, 32'd6, 8'd0, 3, ST_INVALID);
		push_frame(1'b0, 32'd1, 32'd2, 8'd0, 2, ST_TRL_ERR);
		push_frame(1'b0, 32'd1, 32'd2, 8'd0, 1, ST_CRC_ERR);
		push_frame(1'b0, 32'h8000_0000, 32'd2, 8'd0, 0, ST_INVALID);
		push_item(1'b0, SOF0, ST_BYTE);
		push_item(1'b0, SOF0, ST_BYTE);
		push_item(1'b0, 8'h12, ST_BYTE);
		push_item(1'b0, SOF0, ST_BYTE);
		push_item(1'b0, SOF1_LEGACY, ST_BYTE);
		push_ticks(101);
		push_item(1'b0, SOF0, ST_TIMEOUT);
		send_items();
		drain_results();

		// Random phases, each under its own register setting, extremes included.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					config_write(REG_INTERBYTE, 32'd0); config_write(REG_POSE_TO, 32'd0);
					config_write(REG_LINK_TO, 32'd0); config_write(REG_INV_COORD, 32'h7FFF_FFFF);
				end
				1: begin
					config_write(REG_INTERBYTE, 32'd3); config_write(REG_POSE_TO, 32'd20);
					config_write(REG_LINK_TO, 32'd10); config_write(REG_INV_COORD, 32'd0);
				end
				2: begin
					config_write(REG_INTERBYTE, 32'hFFFF); config_write(REG_POSE_TO, 32'hFFFF);
					config_write(REG_LINK_TO, 32'hFFFF);
					config_write(REG_INV_COORD, 32'h8000_0000);
				end
				default: begin
					config_write(REG_INTERBYTE, $urandom_range(1, 12));
					config_write(REG_POSE_TO, $urandom_range(1, 40));
					config_write(REG_LINK_TO, $urandom_range(1, 40));
					config_write(REG_INV_COORD, $urandom);
				end
			endcase
			in_pressure = (ph == 3);
			for (int n = 0; n < 6; n++) begin
				if ($urandom_range(0, 99) < 70) push_random_frame();
				else push_random_noise();
			end
			send_items();
			drain_results();
		end

		$display("Checked %0d result beats, %0d of them valid frames, over five settings.",
			checked, frames_good);
		if (fails == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/pfr_pkg.sv
rtl/pfr_if.sv
rtl/pfr_cfg_regs.sv
rtl/pose_frame_receiver_unit.sv
tb/pose_frame_receiver_unit_tb.sv
